>>> rtl/core/rsl_pkg.sv
// Package for the radial spotlight luma block: widths, constants, register
// indexes and the square-root cell payload type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsl_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int LUMA_BITS_DEF  = 16;

  localparam int CENTER_W   = 14;
  localparam int DX_W       = 15;  // signed pixel minus center
  localparam int ABS_W      = 14;  // |dx|, |dy|
  localparam int SQ_W       = 2 * ABS_W;
  localparam int D2_W       = SQ_W + 1;
  localparam int RAD_W      = 32;  // radicand, d2 << RAD_SHIFT
  localparam int RAD_SHIFT  = 16;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQRT_CELLS = ROOT_W;

  localparam logic [D2_W-1:0]   RADIUS_SQ   = D2_W'(25600);
  localparam logic [ROOT_W-1:0] FULL_SCALE  = ROOT_W'(51200);
  // l/5 == l*10240/51200, so the outer ring shares the scaling path
  localparam logic [ROOT_W-1:0] OUTER_GAIN  = ROOT_W'(10240);
  localparam int                SCALE_SHIFT = 11;  // 51200 = 25 << 11
  localparam int                DIV_RESID   = 25;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_CENTER_COLUMN = 1'b0;
  localparam logic REG_CENTER_ROW    = 1'b1;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;      // radicand bits not yet consumed, MSBs first
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic              outside;  // beyond the radius, root is ignored
  } sq_t;

endpackage

`default_nettype wire

>>> rtl/core/rsl_front.sv
// Front end: pixel-to-center offsets, squares and squared distance, three
// registered stages. Depends on rsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsl_front
  import rsl_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int LUMA_BITS  = LUMA_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        i_valid,
  input  wire logic [COORD_BITS-1:0]       i_column,
  input  wire logic [COORD_BITS-1:0]       i_row,
  input  wire logic [LUMA_BITS-1:0]        i_luma,
  input  wire logic signed [CENTER_W-1:0]  center_column,
  input  wire logic signed [CENTER_W-1:0]  center_row,
  output logic                             adv,
  input  wire logic                        nxt_adv,
  output logic                             o_valid,
  output sq_t                              o_data,
  output logic [LUMA_BITS-1:0]             o_luma
);

  logic                   a_v_r, b_v_r, c_v_r;
  logic                   adv_a, adv_b, adv_c;
  logic [ABS_W-1:0]       ax_r, ay_r, ax_nxt, ay_nxt;
  logic [SQ_W-1:0]        sqx_r, sqy_r;
  logic [LUMA_BITS-1:0]   la_r, lb_r, lc_r;
  logic signed [DX_W-1:0] dx, dy;
  logic [D2_W-1:0]        d2_nxt;
  sq_t                    data_nxt, data_r;

  assign adv_c = !c_v_r || nxt_adv;
  assign adv_b = !b_v_r || adv_c;
  assign adv_a = !a_v_r || adv_b;
  assign adv   = adv_a;

  always_comb begin
    dx = $signed({{(DX_W-COORD_BITS){1'b0}}, i_column}) - DX_W'(center_column);
    dy = $signed({{(DX_W-COORD_BITS){1'b0}}, i_row}) - DX_W'(center_row);
    ax_nxt = dx[DX_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
    ay_nxt = dy[DX_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
  end

  always_comb begin
    d2_nxt           = D2_W'(sqx_r) + D2_W'(sqy_r);
    data_nxt.outside = d2_nxt > RADIUS_SQ;
    data_nxt.rad     = data_nxt.outside ? '0 : RAD_W'({d2_nxt, {RAD_SHIFT{1'b0}}});
    data_nxt.rem     = '0;
    data_nxt.root    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (adv_a) a_v_r <= i_valid;
      if (adv_b) b_v_r <= a_v_r;
      if (adv_c) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      la_r <= i_luma;
    end
    if (adv_b) begin
      sqx_r <= ax_r * ax_r;
      sqy_r <= ay_r * ay_r;
      lb_r  <= la_r;
    end
    if (adv_c) begin
      data_r <= data_nxt;
      lc_r   <= lb_r;
    end
  end

  assign o_valid = c_v_r;
  assign o_data  = data_r;
  assign o_luma  = lc_r;

endmodule

`default_nettype wire

>>> rtl/core/rsl_sqrt_cell.sv
// One cell of the square-root chain: takes two radicand bits, yields one
// root bit, hands the partial result on. Depends on rsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsl_sqrt_cell
  import rsl_pkg::*;
#(
  parameter int LUMA_BITS = LUMA_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 i_valid,
  input  wire sq_t                  i_data,
  input  wire logic [LUMA_BITS-1:0] i_luma,
  output logic                      adv,
  input  wire logic                 nxt_adv,
  output logic                      o_valid,
  output sq_t                       o_data,
  output logic [LUMA_BITS-1:0]      o_luma
);

  logic                 v_r;
  sq_t                  data_r, data_nxt;
  logic [LUMA_BITS-1:0] luma_r;
  logic [REM_W+1:0]     rem_sh, trial, diff;
  logic                 ge;

  assign adv = !v_r || nxt_adv;

  always_comb begin
    rem_sh = {i_data.rem, i_data.rad[RAD_W-1 -: 2]};
    trial  = (REM_W+2)'({i_data.root, 2'b01});
    diff   = rem_sh - trial;
    ge     = rem_sh >= trial;
    data_nxt.rad     = i_data.rad << 2;
    data_nxt.rem     = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    data_nxt.root    = {i_data.root[ROOT_W-2:0], ge};
    data_nxt.outside = i_data.outside;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
      luma_r <= i_luma;
    end
  end

  assign o_valid = v_r;
  assign o_data  = data_r;
  assign o_luma  = luma_r;

endmodule

`default_nettype wire

>>> rtl/core/rsl_scale.sv
// Back end: luma times gain, divide by 51200 (shift, then reciprocal multiply
// by 1/25 with one correction), output register. Depends on rsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsl_scale
  import rsl_pkg::*;
#(
  parameter int LUMA_BITS = LUMA_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 i_valid,
  input  wire sq_t                  i_data,
  input  wire logic [LUMA_BITS-1:0] i_luma,
  output logic                      adv,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [LUMA_BITS-1:0]      out_luma
);

  localparam int PROD_W = LUMA_BITS + ROOT_W;
  localparam int Q_W    = PROD_W - SCALE_SHIFT;
  localparam int R_W    = Q_W - 4;
  localparam logic [R_W-1:0] RECIP = R_W'((64'd1 << Q_W) / 64'd25);

  logic                 m_v_r, e_v_r, o_v_r;
  logic                 adv_m, adv_e, adv_o;
  logic [ROOT_W-1:0]    gain;
  logic [PROD_W-1:0]    prod;
  logic [Q_W-1:0]       q_r, q2_r, est_q, est25, resid;
  logic [Q_W+R_W-1:0]   recip_prod;
  logic [R_W-1:0]       est_r;
  logic [LUMA_BITS-1:0] res_nxt, out_luma_r;

  assign adv_o = !o_v_r || !out_stall;
  assign adv_e = !e_v_r || adv_o;
  assign adv_m = !m_v_r || adv_e;
  assign adv   = adv_m;

  always_comb begin
    gain = i_data.outside ? OUTER_GAIN : FULL_SCALE - i_data.root;
    prod = PROD_W'(i_luma) * PROD_W'(gain);
  end

  assign recip_prod = (Q_W+R_W)'(q_r) * (Q_W+R_W)'(RECIP);

  // estimate is floor(q/25) or one short of it
  always_comb begin
    est_q   = Q_W'(est_r);
    est25   = (est_q << 4) + (est_q << 3) + est_q;
    resid   = q2_r - est25;
    res_nxt = LUMA_BITS'(est_r + R_W'(resid >= Q_W'(DIV_RESID)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      e_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (adv_m) m_v_r <= i_valid;
      if (adv_e) e_v_r <= m_v_r;
      if (adv_o) o_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_m) q_r <= prod[PROD_W-1:SCALE_SHIFT];
    if (adv_e) begin
      est_r <= recip_prod[Q_W+R_W-1:Q_W];
      q2_r  <= q_r;
    end
    if (adv_o) out_luma_r <= res_nxt;
  end

  assign out_valid = o_v_r;
  assign out_luma  = out_luma_r;

endmodule

`default_nettype wire

>>> rtl/core/radial_spotlight_luma_unit.sv
// Radial spotlight luma: dims each pixel's luminance with its distance from
// a programmable center.
// Input channel: in_valid/in_stall with pixel column, row and luma. A
// transaction completes on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with out_luma_out, one result per input
// transaction, in order.
// Pipeline: 3 offset/square stages, 16 square-root cells, 2 scaling stages
// and an output register between input transaction and out_valid.
// Throughput: one pixel per cycle without out_stall; every stage is one
// register, so the square-root chain sets the rate, one cell per clock.
// Stall: when out_stall holds a result, stages behind it keep moving until
// they fill; in_stall rises only once every stage holds a pixel.
// Configuration over the APB port: center_column at 0x0, center_row at 0x4,
// 14-bit signed; write only while no pixel is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and zeroes the center.
// Depends on rsl_pkg, rsl_front, rsl_sqrt_cell, rsl_scale.
`timescale 1ns / 1ps
`default_nettype none

module radial_spotlight_luma_unit
  import rsl_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int LUMA_BITS  = LUMA_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] in_pixel_column,
  input  wire logic [COORD_BITS-1:0] in_pixel_row,
  input  wire logic [LUMA_BITS-1:0]  in_luma_in,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [LUMA_BITS-1:0]       out_luma_out,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  logic signed [CENTER_W-1:0] center_column_r, center_row_r;
  logic                       cfg_wr;
  logic                       front_adv;

  logic                 cell_v   [0:SQRT_CELLS];
  sq_t                  cell_d   [0:SQRT_CELLS];
  logic [LUMA_BITS-1:0] cell_l   [0:SQRT_CELLS];
  logic                 cell_adv [0:SQRT_CELLS];

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_column_r <= '0;
      center_row_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_CENTER_COLUMN: center_column_r <= cfg_pwdata[CENTER_W-1:0];
        REG_CENTER_ROW:    center_row_r    <= cfg_pwdata[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_CENTER_COLUMN: cfg_prdata = CFG_DATA_W'(center_column_r);
      REG_CENTER_ROW:    cfg_prdata = CFG_DATA_W'(center_row_r);
      default:           cfg_prdata = '0;
    endcase
  end

  assign in_stall = !front_adv;

  rsl_front #(
    .COORD_BITS (COORD_BITS),
    .LUMA_BITS  (LUMA_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .i_valid       (in_valid),
    .i_column      (in_pixel_column),
    .i_row         (in_pixel_row),
    .i_luma        (in_luma_in),
    .center_column (center_column_r),
    .center_row    (center_row_r),
    .adv           (front_adv),
    .nxt_adv       (cell_adv[0]),
    .o_valid       (cell_v[0]),
    .o_data        (cell_d[0]),
    .o_luma        (cell_l[0])
  );

  for (genvar gi = 0; gi < SQRT_CELLS; gi++) begin : g_cell
    rsl_sqrt_cell #(
      .LUMA_BITS (LUMA_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (cell_v[gi]),
      .i_data  (cell_d[gi]),
      .i_luma  (cell_l[gi]),
      .adv     (cell_adv[gi]),
      .nxt_adv (cell_adv[gi+1]),
      .o_valid (cell_v[gi+1]),
      .o_data  (cell_d[gi+1]),
      .o_luma  (cell_l[gi+1])
    );
  end

  rsl_scale #(
    .LUMA_BITS (LUMA_BITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .i_valid   (cell_v[SQRT_CELLS]),
    .i_data    (cell_d[SQRT_CELLS]),
    .i_luma    (cell_l[SQRT_CELLS]),
    .adv       (cell_adv[SQRT_CELLS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_luma  (out_luma_out)
  );

endmodule

`default_nettype wire

>>> rtl/core/rsl_checker.sv
// Port-level checks for radial_spotlight_luma_unit, attached by bind.
// Depends on rsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsl_checker
  import rsl_pkg::*;
#(
  parameter int LUMA_BITS = LUMA_BITS_DEF
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [LUMA_BITS-1:0] out_luma_out
);

  // a held result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_luma_out))
    else $error("result changed while stalled");

  // a result only disappears after a transaction or reset
  a_out_drop: assert property (@(posedge clk)
    $fell(out_valid) |-> ($past(!out_stall) || !$past(rst_n)))
    else $error("result dropped without transaction");

  // with the output register empty, the pipeline can always move
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind radial_spotlight_luma_unit rsl_checker #(.LUMA_BITS(LUMA_BITS)) u_rsl_checker (.*);

`default_nettype wire

>>> bench/radial_spotlight_luma_unit_test.sv
// Self-checking bench for radial_spotlight_luma_unit: drives pixels and APB center writes,
// predicts each dimmed luma in-bench and checks results in order.
// Depends on rsl_pkg and the radial_spotlight_luma_unit RTL.
`timescale 1ns / 1ps

module radial_spotlight_luma_unit_test;
  import rsl_pkg::*;

  localparam int     COORD_W      = COORD_BITS_DEF;
  localparam int     LUMA_W       = LUMA_BITS_DEF;
  localparam longint SPOT_RAD_SQ  = 25600;  // 160 squared
  localparam longint SPOT_SCALE   = 51200;  // 0.005 per unit in Q.8 distance
  localparam longint OUTER_DIV    = 5;      // factor 0.2 outside the spot
  localparam int     SETTLE_CYC   = 30;     // longer than the pipeline
  localparam int     CYCLE_LIMIT  = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COORD_W-1:0]    in_pixel_column = '0;
  logic [COORD_W-1:0]    in_pixel_row = '0;
  logic [LUMA_W-1:0]     in_luma_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LUMA_W-1:0]     out_luma_out;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic signed [CENTER_W-1:0] center_column_q = '0;
  logic signed [CENTER_W-1:0] center_row_q = '0;
  logic [LUMA_W-1:0]          luma_expected[$];
  bit                         idling = 1'b0;
  int                         stall_left = 0;
  int                         errors = 0;
  int                         cycle_count = 0;

  radial_spotlight_luma_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_column (in_pixel_column),
    .in_pixel_row    (in_pixel_row),
    .in_luma_in      (in_luma_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_luma_out    (out_luma_out),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Expected luma from the current center; distance kept in Q.8 via a bitwise root.
  function automatic logic [LUMA_W-1:0] dimmed_luma(logic [COORD_W-1:0] col,
                                                    logic [COORD_W-1:0] row,
                                                    logic [LUMA_W-1:0] luma);
    longint dx, dy, d2, radicand, root, trial;
    dx = longint'(col) - longint'(center_column_q);
    dy = longint'(row) - longint'(center_row_q);
    d2 = dx * dx + dy * dy;
    if (d2 > SPOT_RAD_SQ) return LUMA_W'(longint'(luma) / OUTER_DIV);
    radicand = d2 << 16;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= radicand) root = trial;
    end
    return LUMA_W'((longint'(luma) * (SPOT_SCALE - root)) / SPOT_SCALE);
  endfunction

  // Result side: check at each accepting edge, then pick the next stall state.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (luma_expected.size() == 0) begin
        $error("luma_out unexpected transaction: actual %0d", out_luma_out);
        errors++;
      end else begin
        if (out_luma_out !== luma_expected[0]) begin
          $error("luma_out mismatch: expected %0d, actual %0d",
                 luma_expected[0], out_luma_out);
          errors++;
        end
        void'(luma_expected.pop_front());
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                            input logic [LUMA_W-1:0] luma);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_pixel_column <= col;
    in_pixel_row    <= row;
    in_luma_in      <= luma;
    do @(posedge clk); while (in_stall);
    luma_expected.push_back(dimmed_luma(col, row, luma));
  endtask

  // Stop sending and let every pixel in flight come out.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (luma_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // APB write; upper data bits are noise the block must drop.
  task automatic write_center(input logic idx, input logic signed [CENTER_W-1:0] value);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    data[CENTER_W-1:0] = value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_CENTER_COLUMN) center_column_q = value;
    else center_row_q = value;
  endtask

  task automatic set_center(input logic signed [CENTER_W-1:0] col,
                            input logic signed [CENTER_W-1:0] row);
    drain_pipeline();
    write_center(REG_CENTER_COLUMN, col);
    write_center(REG_CENTER_ROW, row);
  endtask

  function automatic logic [COORD_W-1:0] near_coord(int center);
    int c;
    c = center + int'($urandom_range(0, 400)) - 200;
    if (c < 0) c = 0;
    if (c > (1 << COORD_W) - 1) c = (1 << COORD_W) - 1;
    return COORD_W'(c);
  endfunction

  function automatic logic [LUMA_W-1:0] pick_luma();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return LUMA_W'($urandom);
    endcase
  endfunction

  // Center at reset is the origin; covers the rim of the spot from both sides.
  task automatic test_reset_center();
    send_pixel(0, 0, '1);
    send_pixel(0, 0, '0);
    send_pixel(1, 0, '1);
    send_pixel(1, 1, 16'h8001);
    send_pixel(160, 0, '1);
    send_pixel(0, 160, 16'h1234);
    send_pixel(96, 128, '1);   // exactly on the rim
    send_pixel(161, 0, '1);
    send_pixel(113, 114, '1);  // just past the rim
    send_pixel('1, '1, '1);
  endtask

  // Centers at the register extremes, well outside the image, then inside it.
  task automatic test_center_extremes();
    set_center(-14'sd8192, 14'sd8191);
    send_pixel(0, 0, '1);
    send_pixel('1, '1, '1);
    set_center(14'sd8191, -14'sd8192);
    send_pixel('1, 0, 16'hFFFE);
    send_pixel(0, '1, '1);
    set_center(-14'sd1, -14'sd1);
    send_pixel(0, 0, '1);
    send_pixel(112, 112, '1);
    set_center(14'sd2048, 14'sd1024);
    send_pixel(2048, 1024, '1);
    send_pixel(2208, 1024, '1);
    send_pixel(2047, 1023, 16'hAAAA);
    send_pixel(1984, 1168, '1);  // offset (-64,144), inside
  endtask

  task automatic test_random_pixels();
    logic signed [CENTER_W-1:0] ccol, crow;
    logic [COORD_W-1:0] col, row;
    for (int phase = 0; phase < 11; phase++) begin
      if ($urandom_range(0, 3) == 0) begin
        ccol = CENTER_W'($urandom);
        crow = CENTER_W'($urandom);
      end else begin
        ccol = CENTER_W'($urandom_range(0, (1 << COORD_W) - 1));
        crow = CENTER_W'($urandom_range(0, (1 << COORD_W) - 1));
      end
      set_center(ccol, crow);
      // last phase runs without any idling on either side
      idling = (phase < 10) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 9) < 6) begin
          col = near_coord(int'(ccol));
          row = near_coord(int'(crow));
        end else begin
          col = COORD_W'($urandom);
          row = COORD_W'($urandom);
        end
        send_pixel(col, row, pick_luma());
      end
    end
    idling = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_center();
    test_center_extremes();
    test_random_pixels();
    drain_pipeline();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rsl_pkg.sv
rtl/core/rsl_front.sv
rtl/core/rsl_sqrt_cell.sv
rtl/core/rsl_scale.sv
rtl/core/radial_spotlight_luma_unit.sv
rtl/core/rsl_checker.sv
bench/radial_spotlight_luma_unit_test.sv
